// ===== rtl/rmf_pkg.sv =====
// ---------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the centred running median filter
// Payload structs of both channels, control structs for the cell row, and
// the defaults of the window register.
// ---------------------------------------------------------------------------
package rmf_pkg;

    // default number of cells in the row
    localparam int MAX_WINDOW_DEF = 32;

    // window length register
    localparam int         WLEN_W     = 6;
    localparam logic [5:0] WLEN_RESET = 6'd3;

    // sample width
    localparam int DATA_W = 32;

    // action codes of an input item
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] median;
        logic                     last;
    } out_item_t;

    // operation applied to every cell in the row at once
    typedef struct packed {
        logic ins;
        logic drop;
        logic clr;
    } cell_op_t;

    // control from the sequencer to the window
    typedef struct packed {
        cell_op_t op;
        logic     pick;
    } win_ctrl_t;

endpackage

// ===== rtl/rmf_cell.sv =====
// ---------------------------------------------------------------------------
// rmf_cell: one slot of the sorted window
// Holds a sample, its age (inserts since it arrived) and a valid bit.
// Shifts right on an insert below it, left on a removal at or before it.
// ---------------------------------------------------------------------------
module rmf_cell #(
    parameter int AGE_W = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rmf_pkg::cell_op_t                  op,
    input  logic signed [rmf_pkg::DATA_W-1:0]  sample,
    input  logic [AGE_W-1:0]                   oldest_age,
    // neighbour towards lower values
    input  logic signed [rmf_pkg::DATA_W-1:0]  left_value,
    input  logic [AGE_W-1:0]                   left_age,
    input  logic                               left_valid,
    input  logic                               left_gt,
    // neighbour towards higher values
    input  logic signed [rmf_pkg::DATA_W-1:0]  right_value,
    input  logic [AGE_W-1:0]                   right_age,
    input  logic                               right_valid,
    // removal point found left of this cell
    input  logic                               seen_in,
    output logic                               seen_out,
    output logic                               gt,
    output logic signed [rmf_pkg::DATA_W-1:0]  value,
    output logic [AGE_W-1:0]                   age,
    output logic                               valid
);
    import rmf_pkg::*;

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [AGE_W-1:0]         age_reg, age_next;
    logic                     valid_reg, valid_next;
    logic                     hit;
    logic                     seen;

    // an empty cell counts as above every sample
    assign gt       = !valid_reg || (value_reg > sample);
    assign hit      = valid_reg && (age_reg == oldest_age);
    assign seen     = seen_in || hit;
    assign seen_out = seen;

    // next contents of the cell
    always_comb
    begin
        value_next = value_reg;
        age_next   = age_reg;
        valid_next = valid_reg;
        if (op.clr)
        begin
            valid_next = 1'b0;
        end
        else if (op.ins)
        begin
            if (gt && left_gt)
            begin
                value_next = left_value;
                age_next   = left_age + AGE_W'(1);
                valid_next = left_valid;
            end
            else if (gt)
            begin
                value_next = sample;
                age_next   = '0;
                valid_next = 1'b1;
            end
            else
            begin
                age_next = age_reg + AGE_W'(1);
            end
        end
        else if (op.drop && seen)
        begin
            value_next = right_value;
            age_next   = right_age;
            valid_next = right_valid;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign value = value_reg;
    assign age   = age_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/rmf_window.sv =====
// ---------------------------------------------------------------------------
// rmf_window: row of cells holding the window in ascending order
// Cells trade contents with their neighbours on insert and removal; the two
// middle values are captured into registers on a pick.
// ---------------------------------------------------------------------------
module rmf_window #(
    parameter int MAX_WINDOW = 32,
    parameter int AGE_W      = 5,
    parameter int FILL_W     = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rmf_pkg::win_ctrl_t                 ctrl,
    input  logic signed [rmf_pkg::DATA_W-1:0]  sample,
    input  logic [AGE_W-1:0]                   oldest_age,
    input  logic [FILL_W-1:0]                  fill,
    output logic signed [rmf_pkg::DATA_W-1:0]  mid_hi,
    output logic signed [rmf_pkg::DATA_W-1:0]  mid_lo,
    output logic [MAX_WINDOW-1:0]              valid_vec
);
    import rmf_pkg::*;

    logic signed [DATA_W-1:0] value_w [MAX_WINDOW];
    logic [AGE_W-1:0]         age_w   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]    gt_w;
    logic [MAX_WINDOW-1:0]    seen_w;

    logic signed [DATA_W-1:0] mid_hi_reg, mid_hi_next;
    logic signed [DATA_W-1:0] mid_lo_reg, mid_lo_next;
    logic [FILL_W-1:0]        hi_idx;
    logic [FILL_W-1:0]        lo_idx;

    // chain of cells
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] lv, rv;
        logic [AGE_W-1:0]         la, ra;
        logic                     lval, lgt, rval, sin;

        if (i == 0)
        begin : g_first
            assign lv   = '0;
            assign la   = '0;
            assign lval = 1'b0;
            assign lgt  = 1'b0;
            assign sin  = 1'b0;
        end
        else
        begin : g_mid
            assign lv   = value_w[i-1];
            assign la   = age_w[i-1];
            assign lval = valid_vec[i-1];
            assign lgt  = gt_w[i-1];
            assign sin  = seen_w[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign rv   = '0;
            assign ra   = '0;
            assign rval = 1'b0;
        end
        else
        begin : g_inner
            assign rv   = value_w[i+1];
            assign ra   = age_w[i+1];
            assign rval = valid_vec[i+1];
        end

        rmf_cell #(
            .AGE_W (AGE_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (ctrl.op),
            .sample      (sample),
            .oldest_age  (oldest_age),
            .left_value  (lv),
            .left_age    (la),
            .left_valid  (lval),
            .left_gt     (lgt),
            .right_value (rv),
            .right_age   (ra),
            .right_valid (rval),
            .seen_in     (sin),
            .seen_out    (seen_w[i]),
            .gt          (gt_w[i]),
            .value       (value_w[i]),
            .age         (age_w[i]),
            .valid       (valid_vec[i])
        );
    end

    // middle positions: fill/2 and the one below it
    assign hi_idx = fill >> 1;
    assign lo_idx = hi_idx - FILL_W'(1);

    // and-or selection of the middle cells
    always_comb
    begin
        mid_hi_next = mid_hi_reg;
        mid_lo_next = mid_lo_reg;
        if (ctrl.pick)
        begin
            mid_hi_next = '0;
            mid_lo_next = '0;
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                if (hi_idx == FILL_W'(i))
                    mid_hi_next = mid_hi_next | value_w[i];
                if (lo_idx == FILL_W'(i))
                    mid_lo_next = mid_lo_next | value_w[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mid_hi_reg <= mid_hi_next;
        mid_lo_reg <= mid_lo_next;
    end

    assign mid_hi = mid_hi_reg;
    assign mid_lo = mid_lo_reg;

endmodule

// ===== rtl/centered_running_median_filter.sv =====
// ---------------------------------------------------------------------------
// centered_running_median_filter: centred running median over 32-bit samples
// Sorted window kept in a row of cells, each tagged with its age; a small
// sequencer removes the oldest sample, inserts the new one and emits the
// median of the window.
//
//   channel   direction  handshake            payload
//   sample    in         sample_valid/stall   in_item_t  (action, sample)
//   result    out        result_valid/stall   out_item_t (median, last)
//   cfg       in         cfg_valid/ready      window length, 6 bits
//
// A sample is inserted, after a removal once the window is full (removal and
// insert are separate passes over the cell row); if it yields a result, the
// middle values are then picked and the median calculated. A flush yields
// each result by a removal, a pick and a calculation, and clears the window
// when it yields none. Reset empties the window and sets the window length
// to 3. A stalled result waits in the output register while the next item
// is taken; the sequencer holds in its final step only if a second result
// is ready before the first is transferred.
// ---------------------------------------------------------------------------
module centered_running_median_filter #(
    parameter int MAX_WINDOW = rmf_pkg::MAX_WINDOW_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  rmf_pkg::in_item_t                sample_item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output rmf_pkg::out_item_t               result_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rmf_pkg::WLEN_W-1:0]       cfg_data
);
    import rmf_pkg::*;

    localparam int AGE_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (FILL_W > WLEN_W) ? FILL_W : WLEN_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DROP = 5'b00010,
        S_INS  = 5'b00100,
        S_PICK = 5'b01000,
        S_CALC = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [WLEN_W-1:0]        wlen_reg, wlen_next;
    logic                     flush_reg, flush_next;
    logic                     emit_reg, emit_next;
    logic signed [DATA_W-1:0] smp_reg, smp_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_item_reg, out_item_next;

    win_ctrl_t                ctrl;
    logic signed [DATA_W-1:0] mid_hi, mid_lo;
    logic [MAX_WINDOW-1:0]    valid_vec;
    logic [AGE_W-1:0]         oldest_age;
    logic [FILL_W-1:0]        fill_dec;

    logic [CMP_W-1:0]         wlen_ext;
    logic [CMP_W-1:0]         eff_w;
    logic [CMP_W-1:0]         half_w;
    logic [CMP_W-1:0]         fill_ext;
    logic                     sample_fire;
    logic                     cfg_fire;
    logic                     out_load;
    logic                     last_flag;

    logic signed [DATA_W:0]   pair_sum;
    logic signed [DATA_W:0]   pair_adj;
    logic signed [DATA_W-1:0] median_val;

    // effective window length, clamped to 1..MAX_WINDOW
    assign wlen_ext = CMP_W'(wlen_reg);
    always_comb
    begin
        if (wlen_ext == '0)
            eff_w = CMP_W'(1);
        else if (wlen_ext > CMP_W'(MAX_WINDOW))
            eff_w = CMP_W'(MAX_WINDOW);
        else
            eff_w = wlen_ext;
    end
    assign half_w   = eff_w >> 1;
    assign fill_ext = CMP_W'(fill_reg);

    // oldest entry carries age fill-1
    assign fill_dec   = fill_reg - FILL_W'(1);
    assign oldest_age = fill_dec[AGE_W-1:0];

    // handshakes
    assign cfg_ready    = (state_reg == S_IDLE);
    assign sample_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_fire     = cfg_valid && cfg_ready;
    assign sample_fire  = sample_valid && !sample_stall;
    assign out_load     = (state_reg == S_CALC) && (!out_valid_reg || !result_stall);

    // a flush ends once the window is down to half plus one
    assign last_flag = !flush_reg || (fill_ext <= half_w + CMP_W'(1));

    // median: odd count takes the middle, even count halves the pair sum
    // with rounding toward zero
    assign pair_sum   = {mid_hi[DATA_W-1], mid_hi} + {mid_lo[DATA_W-1], mid_lo};
    assign pair_adj   = pair_sum + (DATA_W+1)'(pair_sum[DATA_W]);
    assign median_val = fill_reg[0] ? mid_hi : pair_adj[DATA_W:1];

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        wlen_next     = wlen_reg;
        flush_next    = flush_reg;
        emit_next     = emit_reg;
        smp_next      = smp_reg;
        out_item_next = out_item_reg;
        ctrl          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_fire)
                begin
                    wlen_next    = cfg_data;
                    fill_next    = '0;
                    ctrl.op.clr  = 1'b1;
                end
                else if (sample_fire)
                begin
                    smp_next = sample_item.sample;
                    if (sample_item.action == ACT_SAMPLE)
                    begin
                        flush_next = 1'b0;
                        if (fill_ext < half_w)
                        begin
                            emit_next  = 1'b0;
                            state_next = S_INS;
                        end
                        else if (fill_ext >= eff_w)
                        begin
                            emit_next  = 1'b1;
                            state_next = S_DROP;
                        end
                        else
                        begin
                            emit_next  = 1'b1;
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        flush_next = 1'b1;
                        emit_next  = 1'b1;
                        if (fill_ext > half_w + CMP_W'(1))
                        begin
                            state_next = S_DROP;
                        end
                        else
                        begin
                            fill_next   = '0;
                            ctrl.op.clr = 1'b1;
                        end
                    end
                end
            end
            S_DROP:
            begin
                ctrl.op.drop = 1'b1;
                fill_next    = fill_dec;
                state_next   = flush_reg ? S_PICK : S_INS;
            end
            S_INS:
            begin
                ctrl.op.ins = 1'b1;
                fill_next   = fill_reg + FILL_W'(1);
                state_next  = emit_reg ? S_PICK : S_IDLE;
            end
            S_PICK:
            begin
                ctrl.pick  = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (out_load)
                begin
                    out_item_next.median = median_val;
                    out_item_next.last   = last_flag;
                    if (!last_flag)
                    begin
                        state_next = S_DROP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        if (flush_reg)
                        begin
                            fill_next   = '0;
                            ctrl.op.clr = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            wlen_reg      <= WLEN_RESET;
            flush_reg     <= 1'b0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            wlen_reg      <= wlen_next;
            flush_reg     <= flush_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg      <= smp_next;
        out_item_reg <= out_item_next;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    // sorted window
    rmf_window #(
        .MAX_WINDOW (MAX_WINDOW),
        .AGE_W      (AGE_W),
        .FILL_W     (FILL_W)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sample     (smp_reg),
        .oldest_age (oldest_age),
        .fill       (fill_reg),
        .mid_hi     (mid_hi),
        .mid_lo     (mid_lo),
        .valid_vec  (valid_vec)
    );

    // occupied cells always match the fill count
    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(fill_reg))
        else $error("cell occupancy differs from fill count");

    // window never holds more than its configured length
    a_fill_within_window: assert property (@(posedge clk) disable iff (!rst_n)
        fill_ext <= eff_w)
        else $error("fill count beyond window length");

    // final flush result leaves the window empty
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && flush_reg && last_flag) |=> (fill_reg == '0))
        else $error("window not cleared after flush");

    // a removal only happens on a non-empty window
    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DROP) |-> (fill_reg != '0))
        else $error("removal from empty window");

endmodule
